FILE: rtl/swcnt_pkg.sv
// Shared types, constants and helpers of the sliding window event counter.
package swcnt_pkg;

	localparam int DEPTH  = 16;
	localparam int TIME_W = 32;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 3'd0,
		CMD_QUERY = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_START = 3'd3,
		CMD_STOP  = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OKAY        = 2'd0,
		ST_NOT_STARTED = 2'd1,
		ST_OVERFLOW    = 2'd2,
		ST_ALREADY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXPIRE,
		CS_FINISH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic pop;
		logic finish;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic expire_hit;
		logic out_free;
	} dp_stat_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == IDX_W'(DEPTH - 1)) r = '0;
		else r = i + 1'b1;
		return r;
	endfunction

endpackage

FILE: rtl/swcnt_ifs.sv
// Request and response channel interfaces of the sliding window event counter.
interface swcnt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] timestamp;

	modport source (output valid, output cmd, output timestamp, input ready);
	modport sink (input valid, input cmd, input timestamp, output ready);
endinterface

interface swcnt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  event_count;
	logic [31:0] window_time;

	modport source (output valid, output status, output event_count, output window_time,
		input ready);
	modport sink (input valid, input status, input event_count, input window_time,
		output ready);
endinterface

FILE: rtl/swcnt_ctrl.sv
// Controller state machine: take a request, expire old events, then finish it.
module swcnt_ctrl
	import swcnt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CS_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (req_valid) state_d = CS_EXPIRE;
			end
			CS_EXPIRE: begin
				if (!stat.expire_hit) state_d = CS_FINISH;
			end
			CS_FINISH: begin
				if (stat.out_free) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		cmd.load   = 1'b0;
		cmd.pop    = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			CS_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			CS_EXPIRE: begin
				cmd.pop = stat.expire_hit;
			end
			CS_FINISH: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/swcnt_dp.sv
// Datapath: event ring, window registers, window limit and result register.
module swcnt_dp
	import swcnt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         ctl,
	output dp_stat_t          stat,
	input  logic [CMD_W-1:0]  req_cmd,
	input  logic [TIME_W-1:0] req_timestamp,
	input  logic              cfg_wr_en,
	input  logic [TIME_W-1:0] cfg_wr_data,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output logic [STAT_W-1:0] rsp_status,
	output logic [CNT_W-1:0]  rsp_event_count,
	output logic [TIME_W-1:0] rsp_window_time
);

	logic [TIME_W-1:0] ring_q [DEPTH];
	logic [IDX_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  count_q;
	logic              running_q;
	logic [TIME_W-1:0] start_q, stop_q, limit_q;
	cmd_t              cmd_q;
	logic [TIME_W-1:0] ts_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [TIME_W-1:0] out_time_q;

	logic [TIME_W-1:0] age, diff, slid_start, sat_time, wt;
	logic              slide, past_limit, full;
	logic [IDX_W-1:0]  head_d, tail_d;
	logic [CNT_W-1:0]  count_d;
	logic              running_d, wr_en;
	logic [TIME_W-1:0] start_d, stop_d;
	status_t           status_d;

	assign slide = running_q &&
		(cmd_q == CMD_ADD || cmd_q == CMD_QUERY || cmd_q == CMD_STOP);
	assign age   = ts_q - ring_q[tail_q];
	assign stat.expire_hit = slide && (count_q != '0) && (age >= limit_q);
	assign stat.out_free   = !out_valid_q || rsp_ready;

	assign diff       = ts_q - start_q;
	assign past_limit = diff >= limit_q;
	assign slid_start = past_limit ? (ts_q - limit_q) : start_q;
	assign sat_time   = past_limit ? limit_q : diff;
	assign full       = count_q == CNT_W'(DEPTH);

	// effect of the finished request on the window state
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		running_d = running_q;
		start_d   = start_q;
		stop_d    = stop_q;
		wr_en     = 1'b0;
		status_d  = ST_OKAY;
		case (cmd_q)
			CMD_ADD: begin
				if (running_q) begin
					start_d = slid_start;
					wr_en   = 1'b1;
					head_d  = ring_next(head_q);
					if (full) begin
						tail_d   = ring_next(tail_q);
						status_d = ST_OVERFLOW;
					end else begin
						count_d = count_q + 1'b1;
					end
				end else begin
					status_d = ST_NOT_STARTED;
				end
			end
			CMD_QUERY: begin
				if (running_q) start_d = slid_start;
			end
			CMD_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			CMD_START: begin
				if (running_q) begin
					status_d = ST_ALREADY;
				end else begin
					running_d = 1'b1;
					start_d   = ts_q;
				end
			end
			CMD_STOP: begin
				if (running_q) begin
					start_d   = slid_start;
					stop_d    = ts_q;
					running_d = 1'b0;
				end else begin
					status_d = ST_NOT_STARTED;
				end
			end
			default: status_d = ST_OKAY;
		endcase
	end

	// while running the window length saturates at the limit; a fresh start reads zero
	always_comb begin
		if (running_q) wt = sat_time;
		else if (cmd_q == CMD_START) wt = '0;
		else wt = stop_q - start_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.finish && wr_en) ring_q[head_q] <= ts_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_t'(req_cmd);
			ts_q  <= req_timestamp;
		end
		if (ctl.finish) begin
			out_status_q <= status_d;
			out_count_q  <= count_d;
			out_time_q   <= wt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			running_q   <= 1'b0;
			start_q     <= '0;
			stop_q      <= '0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en && !running_q) limit_q <= cfg_wr_data;
			if (ctl.pop) begin
				// drop the oldest event
				tail_q  <= ring_next(tail_q);
				count_q <= count_q - 1'b1;
			end else if (ctl.finish) begin
				head_q    <= head_d;
				tail_q    <= tail_d;
				count_q   <= count_d;
				running_q <= running_d;
				start_q   <= start_d;
				stop_q    <= stop_d;
			end
			if (ctl.finish) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_status      = out_status_q;
	assign rsp_event_count = out_count_q;
	assign rsp_window_time = out_time_q;

endmodule

FILE: rtl/sliding_window_event_counter_unit.sv
// Top level of the sliding window event counter.
//
//  channel | direction | payload                                  | handshake
//  req     | in        | cmd[2:0], timestamp[31:0]                | valid / ready
//  rsp     | out       | status[1:0], event_count[4:0], window_time[31:0] | valid / ready
//  cfg     | in        | cfg_wr_data[31:0] (window limit)         | cfg_wr_en
//
// One request at a time; the expiry loop pops the oldest ring entry once per cycle
// for as long as that entry has expired, before the request is finished.
// The result sits in an output register; the next request is taken while it waits.
// A request is finished only when the output register is free, so a stalled rsp holds it.
// arst_n clears the ring pointers, count, run flag, window registers and window limit.
module sliding_window_event_counter_unit
	import swcnt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	swcnt_req_if.sink         req,
	swcnt_rsp_if.source       rsp,
	input  logic              cfg_wr_en,
	input  logic [TIME_W-1:0] cfg_wr_data
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	swcnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (ctl)
	);

	swcnt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.req_cmd         (req.cmd),
		.req_timestamp   (req.timestamp),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_event_count (rsp.event_count),
		.rsp_window_time (rsp.window_time)
	);

endmodule
